// File: hw/rtl/baro_pkg.sv
// Shared types, widths and constants of the barometric compensation block.
package baro_pkg;

	// Field and register widths
	localparam int RAW_W       = 24;
	localparam int CAL_W       = 16;
	localparam int NUM_CAL     = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int TEMP_OUT_W  = 15;
	localparam int PRESS_OUT_W = 17;

	// Datapath widths: dT, working temperature, OFF/SENS, multiplier port, accumulator
	localparam int DT_W    = RAW_W + 1;
	localparam int TEMP_W  = 20;
	localparam int WIDE_W  = 42;
	localparam int MUL_W   = 26;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int ACC_W   = 64;
	localparam int SHAMT_W = 5;

	// Coefficient register indexes
	localparam logic [CFG_IDX_W-1:0] CAL_C1 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CAL_C2 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CAL_C3 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CAL_C4 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CAL_C5 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CAL_C6 = 3'd5;

	// Conversion kinds carried in the input tuser
	localparam logic KIND_TEMP  = 1'b0;
	localparam logic KIND_PRESS = 1'b1;

	// Power-of-two scalings of the integer compensation
	localparam int C5_SH        = 8;
	localparam int OFF_BASE_SH  = 16;
	localparam int SENS_BASE_SH = 15;
	localparam logic [SHAMT_W-1:0] SH_NONE  = 5'd0;
	localparam logic [SHAMT_W-1:0] SH_HALF  = 5'd1;
	localparam logic [SHAMT_W-1:0] SH_QUART = 5'd2;
	localparam logic [SHAMT_W-1:0] SH_OFF   = 5'd7;
	localparam logic [SHAMT_W-1:0] SH_SENS  = 5'd8;
	localparam logic [SHAMT_W-1:0] SH_P     = 5'd15;
	localparam logic [SHAMT_W-1:0] SH_SCALE = 5'd21;
	localparam logic [SHAMT_W-1:0] SH_TEMP  = 5'd23;
	localparam logic [SHAMT_W-1:0] SH_T2    = 5'd31;

	// Temperature thresholds and output limits
	localparam logic signed [TEMP_W-1:0] TEMP_REF    = 20'sd2000;
	localparam logic signed [TEMP_W-1:0] TEMP_FRIGID = -20'sd1500;
	localparam logic signed [TEMP_W-1:0] TEMP_LO     = -20'sd4000;
	localparam logic signed [TEMP_W-1:0] TEMP_HI     = 20'sd8500;
	localparam logic signed [ACC_W-1:0]  PRESS_LO    = 64'sd1000;
	localparam logic signed [ACC_W-1:0]  PRESS_HI    = 64'sd120000;

	typedef logic [NUM_CAL-1:0][CAL_W-1:0] cal_arr_t;

	// One operation of the shared multiply-accumulate unit
	typedef struct packed {
		logic                     go;
		logic signed [MUL_W-1:0]  a;
		logic signed [MUL_W-1:0]  b;
		logic                     shl;      // product scaled up by 2^RAW_W
		logic [SHAMT_W-1:0]       rsh;      // truncating division by 2^rsh
		logic                     use_acc;  // divide the accumulator instead of the product
		logic                     use_init; // start from init instead of the accumulator
		logic                     neg;      // subtract the term
		logic signed [WIDE_W-1:0] init;
	} mac_op_t;

	// Finished result handed to the output register
	typedef struct packed {
		logic                   valid;
		logic [TEMP_OUT_W-1:0]  temp;
		logic [PRESS_OUT_W-1:0] press;
		logic                   clipped;
	} baro_res_t;

endpackage

// File: hw/rtl/baro_mac.sv
// Shared multiply, truncating-shift and accumulate unit, three stages deep.
module baro_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  baro_pkg::mac_op_t                 op,
	output logic                              done,
	output logic signed [baro_pkg::ACC_W-1:0] acc
);
	import baro_pkg::*;

	logic                     v_s1, v_s2, done_q;
	mac_op_t                  ctl_s1, ctl_s2;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  term_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext, term_pre, term_b, term_t, base;
	logic [ACC_W-1:0]         bias;

	// Stage two: pick the term and divide it by 2^rsh, rounding toward zero
	always_comb begin
		prod_ext = {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		if (ctl_s1.use_acc) begin
			term_pre = acc_q;
		end else if (ctl_s1.shl) begin
			term_pre = prod_ext <<< RAW_W;
		end else begin
			term_pre = prod_ext;
		end
		bias   = term_pre[ACC_W-1] ? ~({ACC_W{1'b1}} << ctl_s1.rsh) : '0;
		term_b = term_pre + $signed(bias);
		term_t = term_b >>> ctl_s1.rsh;
	end

	// Stage three: base value for the accumulate
	always_comb begin
		if (ctl_s2.use_init) begin
			base = {{(ACC_W-WIDE_W){ctl_s2.init[WIDE_W-1]}}, ctl_s2.init};
		end else begin
			base = acc_q;
		end
	end

	// Valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= op.go;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (op.go) begin
			prod_s1 <= $signed(op.a) * $signed(op.b);
			ctl_s1  <= op;
		end
		if (v_s1) begin
			term_s2 <= term_t;
			ctl_s2  <= ctl_s1;
		end
		if (v_s2) begin
			acc_q <= ctl_s2.neg ? (base - term_s2) : (base + term_s2);
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

	// Only one operation is in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		op.go |=> !op.go && !v_s2)
		else $error("shared unit issued while busy");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> v_s2 ##1 done_q)
		else $error("shared unit pipeline lost an operation");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !v_s1 && !v_s2)
		else $error("shared unit completion overlaps another operation");

endmodule

// File: hw/rtl/baro_seq.sv
// Sequencer that runs the compensation formula through the shared unit.
module baro_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [baro_pkg::RAW_W-1:0]        d1,
	input  logic [baro_pkg::RAW_W-1:0]        d2,
	input  baro_pkg::cal_arr_t                cal,
	input  logic                              res_free,
	output logic                              idle,
	output baro_pkg::baro_res_t               res,
	output baro_pkg::mac_op_t                 mac_op,
	input  logic                              mac_done,
	input  logic signed [baro_pkg::ACC_W-1:0] mac_acc
);
	import baro_pkg::*;

	localparam int XW = TEMP_W + 1;
	localparam int KW = TEMP_W + 5;

	typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE} state_t;
	typedef enum logic [3:0] {
		OP_TEMP, OP_OFF, OP_SENS, OP_OFF2A, OP_SENS2A, OP_OFF2B, OP_SENS2B,
		OP_T2, OP_PLO, OP_PHI, OP_PSH, OP_PFIN
	} op_t;

	state_t                   state_q;
	op_t                      op_q, op_next;
	logic signed [DT_W-1:0]   dt_q;
	logic [RAW_W-1:0]         d1_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic signed [WIDE_W-1:0] off_q, sens_q;
	logic                     cold, frigid;
	logic signed [XW-1:0]     x_w, y_w;
	logic signed [KW-1:0]     x5_w, y7_w, y11_w;
	logic signed [TEMP_W-1:0] temp_clip;
	logic signed [ACC_W-1:0]  press_clip;
	logic                     clip_t, clip_p;

	// Low-temperature branches use the first-order temperature
	assign cold   = temp_q < TEMP_REF;
	assign frigid = temp_q < TEMP_FRIGID;

	// Distances from the thresholds and their small constant multiples
	always_comb begin
		x_w   = XW'(temp_q) - XW'(TEMP_REF);
		y_w   = XW'(temp_q) - XW'(TEMP_FRIGID);
		x5_w  = (KW'(x_w) <<< 2) + KW'(x_w);
		y7_w  = (KW'(y_w) <<< 3) - KW'(y_w);
		y11_w = (KW'(y_w) <<< 3) + (KW'(y_w) <<< 1) + KW'(y_w);
	end

	// Operation order, skipping the correction terms that do not apply
	always_comb begin
		case (op_q)
			OP_TEMP:   op_next = OP_OFF;
			OP_OFF:    op_next = OP_SENS;
			OP_SENS:   op_next = cold ? OP_OFF2A : OP_PLO;
			OP_OFF2A:  op_next = OP_SENS2A;
			OP_SENS2A: op_next = frigid ? OP_OFF2B : OP_T2;
			OP_OFF2B:  op_next = OP_SENS2B;
			OP_SENS2B: op_next = OP_T2;
			OP_T2:     op_next = OP_PLO;
			OP_PLO:    op_next = OP_PHI;
			OP_PHI:    op_next = OP_PSH;
			OP_PSH:    op_next = OP_PFIN;
			default:   op_next = OP_PFIN;
		endcase
	end

	// Operands and control of the current operation
	always_comb begin
		mac_op    = '0;
		mac_op.go = (state_q == ST_ISSUE);
		case (op_q)
			OP_TEMP: begin
				mac_op.a        = MUL_W'(dt_q);
				mac_op.b        = MUL_W'(cal[CAL_C6]);
				mac_op.rsh      = SH_TEMP;
				mac_op.use_init = 1'b1;
				mac_op.init     = WIDE_W'(TEMP_REF);
			end
			OP_OFF: begin
				mac_op.a        = MUL_W'(dt_q);
				mac_op.b        = MUL_W'(cal[CAL_C4]);
				mac_op.rsh      = SH_OFF;
				mac_op.use_init = 1'b1;
				mac_op.init     = WIDE_W'(cal[CAL_C2]) << OFF_BASE_SH;
			end
			OP_SENS: begin
				mac_op.a        = MUL_W'(dt_q);
				mac_op.b        = MUL_W'(cal[CAL_C3]);
				mac_op.rsh      = SH_SENS;
				mac_op.use_init = 1'b1;
				mac_op.init     = WIDE_W'(cal[CAL_C1]) << SENS_BASE_SH;
			end
			OP_OFF2A: begin
				mac_op.a        = MUL_W'(x_w);
				mac_op.b        = MUL_W'(x5_w);
				mac_op.rsh      = SH_HALF;
				mac_op.use_init = 1'b1;
				mac_op.neg      = 1'b1;
				mac_op.init     = off_q;
			end
			OP_SENS2A: begin
				mac_op.a        = MUL_W'(x_w);
				mac_op.b        = MUL_W'(x5_w);
				mac_op.rsh      = SH_QUART;
				mac_op.use_init = 1'b1;
				mac_op.neg      = 1'b1;
				mac_op.init     = sens_q;
			end
			OP_OFF2B: begin
				mac_op.a        = MUL_W'(y_w);
				mac_op.b        = MUL_W'(y7_w);
				mac_op.rsh      = SH_NONE;
				mac_op.use_init = 1'b1;
				mac_op.neg      = 1'b1;
				mac_op.init     = off_q;
			end
			OP_SENS2B: begin
				mac_op.a        = MUL_W'(y_w);
				mac_op.b        = MUL_W'(y11_w);
				mac_op.rsh      = SH_HALF;
				mac_op.use_init = 1'b1;
				mac_op.neg      = 1'b1;
				mac_op.init     = sens_q;
			end
			OP_T2: begin
				mac_op.a        = MUL_W'(dt_q);
				mac_op.b        = MUL_W'(dt_q);
				mac_op.rsh      = SH_T2;
				mac_op.use_init = 1'b1;
				mac_op.neg      = 1'b1;
				mac_op.init     = WIDE_W'(temp_q);
			end
			OP_PLO: begin
				// Low part of D1*SENS with the unsigned low slice of SENS
				mac_op.a        = MUL_W'(d1_q);
				mac_op.b        = MUL_W'(sens_q[RAW_W-1:0]);
				mac_op.rsh      = SH_NONE;
				mac_op.use_init = 1'b1;
			end
			OP_PHI: begin
				// High part, signed upper slice of SENS, weighted by 2^RAW_W
				mac_op.a   = MUL_W'(d1_q);
				mac_op.b   = MUL_W'($signed(sens_q[WIDE_W-1:RAW_W]));
				mac_op.shl = 1'b1;
				mac_op.rsh = SH_NONE;
			end
			OP_PSH: begin
				// Accumulator becomes OFF - D1*SENS/2^21
				mac_op.rsh      = SH_SCALE;
				mac_op.use_acc  = 1'b1;
				mac_op.use_init = 1'b1;
				mac_op.neg      = 1'b1;
				mac_op.init     = off_q;
			end
			OP_PFIN: begin
				// Negate while dividing: truncation toward zero is symmetric
				mac_op.rsh      = SH_P;
				mac_op.use_acc  = 1'b1;
				mac_op.use_init = 1'b1;
				mac_op.neg      = 1'b1;
			end
			default: begin
				mac_op.go = 1'b0;
			end
		endcase
	end

	// Saturation of both results
	always_comb begin
		clip_t    = 1'b0;
		clip_p    = 1'b0;
		temp_clip = temp_q;
		if (temp_q < TEMP_LO) begin
			temp_clip = TEMP_LO;
			clip_t    = 1'b1;
		end else if (temp_q > TEMP_HI) begin
			temp_clip = TEMP_HI;
			clip_t    = 1'b1;
		end
		press_clip = mac_acc;
		if (mac_acc < PRESS_LO) begin
			press_clip = PRESS_LO;
			clip_p     = 1'b1;
		end else if (mac_acc > PRESS_HI) begin
			press_clip = PRESS_HI;
			clip_p     = 1'b1;
		end
		res.valid   = (state_q == ST_DONE) && res_free;
		res.temp    = temp_clip[TEMP_OUT_W-1:0];
		res.press   = press_clip[PRESS_OUT_W-1:0];
		res.clipped = clip_t || clip_p;
	end

	assign idle = (state_q == ST_IDLE);

	// State, operation index and captured intermediates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_TEMP;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						dt_q    <= $signed({1'b0, d2}) - $signed({1'b0, cal[CAL_C5], {C5_SH{1'b0}}});
						d1_q    <= d1;
						op_q    <= OP_TEMP;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mac_done) begin
						case (op_q)
							OP_TEMP, OP_T2:               temp_q <= mac_acc[TEMP_W-1:0];
							OP_OFF, OP_OFF2A, OP_OFF2B:   off_q  <= mac_acc[WIDE_W-1:0];
							OP_SENS, OP_SENS2A, OP_SENS2B: sens_q <= mac_acc[WIDE_W-1:0];
							default: ;
						endcase
						if (op_q == OP_PFIN) begin
							state_q <= ST_DONE;
						end else begin
							op_q    <= op_next;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == ST_WAIT)
		else $error("shared unit finished outside a wait");

	a_issue_then_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ISSUE |=> state_q == ST_WAIT && !mac_op.go)
		else $error("sequencer issued twice");

	a_res_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |=> state_q == ST_IDLE)
		else $error("sequencer kept running after its result");

endmodule

// File: hw/rtl/baro_sensor_compensation.sv
// Top level: stream ports, coefficient registers, raw stores and output register.
// Each word runs 7 to 12 formula steps on the one shared 26x26 multiply-accumulate
// unit; the low-temperature corrections below 20.00 degC and below -15.00 degC add steps.
// The next input word is accepted only after the result enters the output register,
// so one word is in work at a time, and a stalled output holds the next word off.
// Reset clears coefficients and both stored raws to zero and empties the output.
module baro_sensor_compensation (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [23:0]                        s_axis_tdata,  // [23:0] raw_value
	input  logic                               s_axis_tuser,  // [0] conversion_kind
	// Output stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [31:0]                        m_axis_tdata,  // [14:0] temperature_centi, [31:15] pressure_pascal
	output logic                               m_axis_tuser,  // [0] range_clipped
	// Coefficient writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [baro_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [baro_pkg::CAL_W-1:0]         cfg_data
);
	import baro_pkg::*;

	cal_arr_t                cal_q;
	logic [RAW_W-1:0]        temp_raw_q, press_raw_q;
	logic                    start_q, seq_idle, accept;
	logic                    m_tvalid_q;
	logic [TEMP_OUT_W-1:0]   temp_out_q;
	logic [PRESS_OUT_W-1:0]  press_out_q;
	logic                    clip_out_q;
	baro_res_t               res;
	mac_op_t                 mac_op;
	logic                    mac_done;
	logic signed [ACC_W-1:0] mac_acc;

	assign cfg_ready     = 1'b1;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = seq_idle && !start_q;

	// Coefficient registers; writes past the last register are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_CAL))) begin
			cal_q[cfg_index] <= cfg_data;
		end
	end

	// Raw stores and start of a compensation run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_raw_q  <= '0;
			press_raw_q <= '0;
			start_q     <= 1'b0;
		end else begin
			start_q <= accept;
			if (accept) begin
				if (s_axis_tuser == KIND_PRESS) begin
					press_raw_q <= s_axis_tdata[RAW_W-1:0];
				end else begin
					temp_raw_q <= s_axis_tdata[RAW_W-1:0];
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			temp_out_q  <= res.temp;
			press_out_q <= res.press;
			clip_out_q  <= res.clipped;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {press_out_q, temp_out_q};
	assign m_axis_tuser  = clip_out_q;

	baro_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.d1       (press_raw_q),
		.d2       (temp_raw_q),
		.cal      (cal_q),
		.res_free (!m_tvalid_q || m_axis_tready),
		.idle     (seq_idle),
		.res      (res),
		.mac_op   (mac_op),
		.mac_done (mac_done),
		.mac_acc  (mac_acc)
	);

	baro_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.done   (mac_done),
		.acc    (mac_acc)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("input taken while a word is in work");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(m_tvalid_q && !m_axis_tready))
		else $error("result would overwrite a waiting output word");

	a_out_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> $signed(temp_out_q) >= -15'sd4000 && $signed(temp_out_q) <= 15'sd8500
			&& press_out_q >= 17'd1000 && press_out_q <= 17'd120000)
		else $error("output word outside its saturation range");

endmodule

// File: test/baro_sensor_compensation_tb.sv
// Self-checking testbench for the barometric compensation block: random and directed raw words.
module baro_sensor_compensation_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import baro_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 7;
	localparam int CHUNK_WORDS  = 95;
	localparam int NUM_PHASES   = 8;
	localparam int DRAIN_LIMIT  = 100000;
	localparam int SETTLE_WAIT  = 60;
	localparam longint RAW_MAX  = 64'sd16777215;

	// One raw conversion word and one compensated reading
	typedef struct packed {
		logic             kind;
		logic [RAW_W-1:0] raw;
	} conversion_t;

	typedef struct packed {
		logic signed [TEMP_OUT_W-1:0] temp;
		logic [PRESS_OUT_W-1:0]       press;
		logic                         clipped;
	} reading_t;

	typedef enum int {
		COEF_TYPICAL,
		COEF_ONES,
		COEF_ZEROS,
		COEF_NEAR,
		COEF_RANDOM,
		COEF_MIXED
	} coef_set_t;

	// Factory values of a typical part, C1 through C6
	localparam logic [CAL_W-1:0] TYPICAL_CAL [NUM_CAL] =
		'{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};

	localparam int SEND_IDLE [4]  = '{0, 87, 0, 14};
	localparam int RECV_STALL [4] = '{0, 0, 87, 14};
	localparam coef_set_t PHASE_COEFS [NUM_PHASES] = '{COEF_TYPICAL, COEF_ONES, COEF_ZEROS,
		COEF_NEAR, COEF_RANDOM, COEF_NEAR, COEF_MIXED, COEF_RANDOM};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [23:0]          s_axis_tdata  = '0;
	logic                 s_axis_tuser  = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [31:0]          m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CAL_W-1:0]     cfg_data  = '0;

	// Predictor state: coefficient shadow and the two stored raws
	logic [CAL_W-1:0] cal_shadow [NUM_CAL] = '{default: '0};
	logic [RAW_W-1:0] temp_raw_store  = '0;
	logic [RAW_W-1:0] press_raw_store = '0;

	conversion_t conversions_pending [$];
	reading_t    expected_readings [$];
	conversion_t sent_word;
	reading_t    got_reading;
	reading_t    want_reading;
	int          mismatch_count = 0;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;

	baro_sensor_compensation dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// Signed division by a power of two that truncates toward zero.
	function automatic longint div_pow2(input longint x, input int sh);
		return x / (longint'(1) << sh);
	endfunction

	// Stores the new raw, then runs the integer compensation on both stored raws.
	function automatic reading_t compensate(input conversion_t word);
		longint c1, c2, c3, c4, c5, c6;
		longint d1, d2, dt, t, off, sens, t2, u, v, off2, sens2, p;
		reading_t r;
		if (word.kind == KIND_PRESS) begin
			press_raw_store = word.raw;
		end else begin
			temp_raw_store = word.raw;
		end
		c1 = longint'(cal_shadow[CAL_C1]);
		c2 = longint'(cal_shadow[CAL_C2]);
		c3 = longint'(cal_shadow[CAL_C3]);
		c4 = longint'(cal_shadow[CAL_C4]);
		c5 = longint'(cal_shadow[CAL_C5]);
		c6 = longint'(cal_shadow[CAL_C6]);
		d1 = longint'(press_raw_store);
		d2 = longint'(temp_raw_store);

		dt   = d2 - (c5 << C5_SH);
		t    = TEMP_REF + div_pow2(dt * c6, SH_TEMP);
		off  = (c2 << OFF_BASE_SH) + div_pow2(c4 * dt, SH_OFF);
		sens = (c1 << SENS_BASE_SH) + div_pow2(c3 * dt, SH_SENS);

		// Second-order terms; both thresholds look at the first-order temperature.
		if (t < TEMP_REF) begin
			t2    = div_pow2(dt * dt, SH_T2);
			u     = (t - TEMP_REF) * (t - TEMP_REF);
			off2  = div_pow2(5 * u, SH_HALF);
			sens2 = div_pow2(5 * u, SH_QUART);
			if (t < TEMP_FRIGID) begin
				v     = (t - TEMP_FRIGID) * (t - TEMP_FRIGID);
				off2  = off2 + 7 * v;
				sens2 = sens2 + div_pow2(11 * v, SH_HALF);
			end
			t    = t - t2;
			off  = off - off2;
			sens = sens - sens2;
		end

		p = div_pow2(div_pow2(d1 * sens, SH_SCALE) - off, SH_P);

		// Saturate both outputs and flag any clipping.
		r.clipped = 1'b0;
		if (t < TEMP_LO) begin
			t = TEMP_LO;
			r.clipped = 1'b1;
		end else if (t > TEMP_HI) begin
			t = TEMP_HI;
			r.clipped = 1'b1;
		end
		if (p < PRESS_LO) begin
			p = PRESS_LO;
			r.clipped = 1'b1;
		end else if (p > PRESS_HI) begin
			p = PRESS_HI;
			r.clipped = 1'b1;
		end
		r.temp  = t[TEMP_OUT_W-1:0];
		r.press = p[PRESS_OUT_W-1:0];
		return r;
	endfunction

	// Raw words: mostly near the calibrated operating range, some anywhere, some at the rails.
	function automatic conversion_t random_conversion();
		conversion_t c;
		longint near_raw;
		int pick;
		c.kind = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 8) begin
			c.raw = $urandom_range(1) ? '1 : '0;
		end else if (pick < 35) begin
			c.raw = RAW_W'($urandom);
		end else begin
			if (c.kind == KIND_TEMP) begin
				near_raw = (longint'(cal_shadow[CAL_C5]) << C5_SH)
					+ longint'($urandom_range(4_400_000)) - 64'sd2_200_000;
			end else begin
				near_raw = 64'sd3_000_000 + longint'($urandom_range(8_000_000));
			end
			if (near_raw < 0) begin
				near_raw = 0;
			end else if (near_raw > RAW_MAX) begin
				near_raw = RAW_MAX;
			end
			c.raw = near_raw[RAW_W-1:0];
		end
		return c;
	endfunction

	function automatic conversion_t make_conversion(input logic kind, input logic [RAW_W-1:0] raw);
		conversion_t c;
		c.kind = kind;
		c.raw  = raw;
		return c;
	endfunction

	// One coefficient write; the caller lowers cfg_valid after the last one.
	task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx < NUM_CAL) begin
			cal_shadow[idx] = value;
		end
	endtask

	// Writes all six coefficients, then one index past the end that must be ignored.
	task automatic program_cal(input coef_set_t set);
		logic [CAL_W-1:0] value;
		@(posedge clk);
		for (int i = 0; i < NUM_CAL; i++) begin
			case (set)
				COEF_TYPICAL: value = TYPICAL_CAL[i];
				COEF_ONES:    value = '1;
				COEF_ZEROS:   value = '0;
				COEF_NEAR:    value = TYPICAL_CAL[i] + CAL_W'($urandom_range(4095)) - 16'd2048;
				COEF_RANDOM:  value = CAL_W'($urandom);
				default:      value = $urandom_range(1) ? '1 : '0;
			endcase
			write_cal(CFG_IDX_W'(i), value);
		end
		write_cal(CFG_IDX_W'(NUM_CAL + $urandom_range(1)), CAL_W'($urandom));
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Holds off new words until every queued word is sent and its reading has come back.
	task automatic wait_drained();
		int waited;
		waited = 0;
		while ((conversions_pending.size() > 0 || expected_readings.size() > 0)
				&& waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (waited >= DRAIN_LIMIT) begin
			report_mismatch($sformatf("%0d readings never arrived", expected_readings.size()));
			expected_readings.delete();
		end
	endtask

	// Input driver: presents the oldest pending word, with random gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				sent_word = conversions_pending.pop_front();
				expected_readings.push_back(compensate(sent_word));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (conversions_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= conversions_pending[0].raw;
					s_axis_tuser  <= conversions_pending[0].kind;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each reading against the oldest expectation, stalls at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_reading.temp    = m_axis_tdata[TEMP_OUT_W-1:0];
				got_reading.press   = m_axis_tdata[TEMP_OUT_W +: PRESS_OUT_W];
				got_reading.clipped = m_axis_tuser;
				if (expected_readings.size() == 0) begin
					report_mismatch($sformatf("unexpected reading temp %0d press %0d",
						got_reading.temp, got_reading.press));
				end else begin
					want_reading = expected_readings.pop_front();
					if (got_reading.temp !== want_reading.temp) begin
						report_mismatch($sformatf("temperature %0d, expected %0d",
							got_reading.temp, want_reading.temp));
					end
					if (got_reading.press !== want_reading.press) begin
						report_mismatch($sformatf("pressure %0d, expected %0d",
							got_reading.press, want_reading.press));
					end
					if (got_reading.clipped !== want_reading.clipped) begin
						report_mismatch($sformatf("clip flag %0b, expected %0b",
							got_reading.clipped, want_reading.clipped));
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Stimulus sequence
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Uncalibrated part, and pressure before any temperature has been stored.
		conversions_pending.push_back(make_conversion(KIND_PRESS, 24'd9085466));
		conversions_pending.push_back(make_conversion(KIND_TEMP, 24'd0));
		conversions_pending.push_back(make_conversion(KIND_PRESS, 24'hFFFFFF));
		wait_drained();

		// Typical part: nominal point, rails, and the edges of both cold corrections.
		program_cal(COEF_TYPICAL);
		conversions_pending.push_back(make_conversion(KIND_TEMP, 24'd8569150));
		conversions_pending.push_back(make_conversion(KIND_PRESS, 24'd9085466));
		conversions_pending.push_back(make_conversion(KIND_TEMP, 24'd0));
		conversions_pending.push_back(make_conversion(KIND_TEMP, 24'hFFFFFF));
		conversions_pending.push_back(make_conversion(KIND_PRESS, 24'd0));
		conversions_pending.push_back(make_conversion(KIND_PRESS, 24'hFFFFFF));
		conversions_pending.push_back(make_conversion(KIND_TEMP, 24'd8566784));
		conversions_pending.push_back(make_conversion(KIND_PRESS, 24'h555555));
		conversions_pending.push_back(make_conversion(KIND_TEMP, 24'd8566488));
		conversions_pending.push_back(make_conversion(KIND_TEMP, 24'd8566487));
		conversions_pending.push_back(make_conversion(KIND_PRESS, 24'hAAAAAA));
		conversions_pending.push_back(make_conversion(KIND_TEMP, 24'd8270000));
		conversions_pending.push_back(make_conversion(KIND_TEMP, 24'd7529763));
		conversions_pending.push_back(make_conversion(KIND_TEMP, 24'd7529467));
		conversions_pending.push_back(make_conversion(KIND_TEMP, 24'd7000000));
		conversions_pending.push_back(make_conversion(KIND_PRESS, 24'd6000000));
		conversions_pending.push_back(make_conversion(KIND_TEMP, 24'd8569150));
		wait_drained();

		// Random phases, each with its own coefficients and handshake pressure.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			program_cal(PHASE_COEFS[ph]);
			send_idle_pct  = SEND_IDLE[ph % 4];
			recv_stall_pct = RECV_STALL[ph % 4];
			for (int chunk = 0; chunk < 2; chunk++) begin
				repeat (CHUNK_WORDS) conversions_pending.push_back(random_conversion());
				wait_drained();
			end
		end

		repeat (SETTLE_WAIT) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#10ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
